>>> rtl/ordered_handle_list_macros.svh
// Assertion macros used by the ordered handle list core.
`ifndef ORDERED_HANDLE_LIST_MACROS_SVH
`define ORDERED_HANDLE_LIST_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define OHL_ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ordered_handle_list: property violated");

// Condition must never be seen at a clock edge outside reset.
`define OHL_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("ordered_handle_list: forbidden condition seen");

`endif

>>> rtl/ohl_pkg.sv
// Package: request codes and sequencer state type for the ordered handle list.
package ohl_pkg;

  localparam int REQ_WIDTH = 3;

  localparam logic [REQ_WIDTH-1:0] REQ_APPEND   = 3'd0;
  localparam logic [REQ_WIDTH-1:0] REQ_FIND     = 3'd1;
  localparam logic [REQ_WIDTH-1:0] REQ_READ     = 3'd2;
  localparam logic [REQ_WIDTH-1:0] REQ_REMOVE_H = 3'd3;
  localparam logic [REQ_WIDTH-1:0] REQ_REMOVE_P = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage

>>> rtl/ohl_if.sv
// Valid/ready channel interfaces for requests and responses.
interface ohl_req_if #(
  parameter int HANDLE_WIDTH = 32,
  parameter int POS_WIDTH    = 7
);
  logic                            valid;
  logic                            ready;
  logic [ohl_pkg::REQ_WIDTH-1:0]   req_type;
  logic [HANDLE_WIDTH-1:0]         handle_in;
  logic [POS_WIDTH-1:0]            position_in;

  modport source (output valid, output req_type, output handle_in, output position_in,
                  input ready);
  modport sink (input valid, input req_type, input handle_in, input position_in,
                output ready);
endinterface

interface ohl_rsp_if #(
  parameter int HANDLE_WIDTH = 32,
  parameter int POS_WIDTH    = 7
);
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [HANDLE_WIDTH-1:0] handle_out;
  logic [POS_WIDTH-1:0]    position_out;
  logic                    full_error;
  logic [POS_WIDTH-1:0]    count_out;

  modport source (output valid, output hit, output handle_out, output position_out,
                  output full_error, output count_out, input ready);
  modport sink (input valid, input hit, input handle_out, input position_out,
                input full_error, input count_out, output ready);
endinterface

>>> rtl/ohl_mem.sv
// Handle store: one write port, one read port with registered read data.
module ohl_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ohl_core.sv
// Sequencer and datapath: scans and shifts the handle store one entry per cycle.
`include "ordered_handle_list_macros.svh"

module ohl_core #(
  parameter int DEPTH        = 64,
  parameter int HANDLE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  ohl_req_if.sink   req,
  ohl_rsp_if.source rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE     = CW'(1);

  ohl_pkg::state_t state, state_next;

  logic [ohl_pkg::REQ_WIDTH-1:0] kind, kind_next;
  logic [HANDLE_WIDTH-1:0]       hnd, hnd_next;
  logic [CW-1:0]                 pos, pos_next;
  logic [CW-1:0]                 count, count_next;
  logic [CW-1:0]                 idx, idx_next;
  logic                          rd_pend, rd_pend_next;
  logic [CW-1:0]                 rd_idx, rd_idx_next;
  logic [CW-1:0]                 rd_nxt;

  logic                    r_hit, r_hit_next;
  logic [HANDLE_WIDTH-1:0] r_handle, r_handle_next;
  logic [CW-1:0]           r_pos, r_pos_next;
  logic                    r_full, r_full_next;

  logic                    out_valid;
  logic                    out_load;
  logic                    out_hit;
  logic [HANDLE_WIDTH-1:0] out_handle;
  logic [CW-1:0]           out_pos;
  logic                    out_full;
  logic [CW-1:0]           out_count;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [HANDLE_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [HANDLE_WIDTH-1:0] mem_rdata;

  ohl_mem #(
    .DEPTH (DEPTH),
    .WIDTH (HANDLE_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_nxt    = rd_idx + ONE;
  assign req.ready = (state == ohl_pkg::ST_IDLE);

  assign rsp.valid        = out_valid;
  assign rsp.hit          = out_hit;
  assign rsp.handle_out   = out_handle;
  assign rsp.position_out = out_pos;
  assign rsp.full_error   = out_full;
  assign rsp.count_out    = out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ohl_pkg::ST_IDLE;
      count     <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rd_pend <= rd_pend_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind     <= kind_next;
    hnd      <= hnd_next;
    pos      <= pos_next;
    idx      <= idx_next;
    rd_idx   <= rd_idx_next;
    r_hit    <= r_hit_next;
    r_handle <= r_handle_next;
    r_pos    <= r_pos_next;
    r_full   <= r_full_next;
    if (out_load) begin
      out_hit    <= r_hit;
      out_handle <= r_handle;
      out_pos    <= r_pos;
      out_full   <= r_full;
      out_count  <= count;
    end
  end

  always_comb begin
    state_next    = state;
    kind_next     = kind;
    hnd_next      = hnd;
    pos_next      = pos;
    count_next    = count;
    idx_next      = idx;
    rd_pend_next  = rd_pend;
    rd_idx_next   = rd_idx;
    r_hit_next    = r_hit;
    r_handle_next = r_handle;
    r_pos_next    = r_pos;
    r_full_next   = r_full;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = AW'(rd_idx - ONE);
    mem_wdata     = mem_rdata;
    mem_raddr     = idx[AW-1:0];

    case (state)
      ohl_pkg::ST_IDLE: begin
        // read nth / remove by position fetch their entry right away
        mem_raddr = AW'(req.position_in - ONE);
        if (req.valid) begin
          kind_next     = req.req_type;
          hnd_next      = req.handle_in;
          pos_next      = req.position_in;
          idx_next      = '0;
          rd_pend_next  = 1'b0;
          r_hit_next    = 1'b0;
          r_handle_next = '0;
          r_pos_next    = '0;
          r_full_next   = 1'b0;
          state_next    = ohl_pkg::ST_DONE;
          case (req.req_type)
            ohl_pkg::REQ_APPEND: begin
              if (count < DEPTH_C) begin
                mem_we     = 1'b1;
                mem_waddr  = count[AW-1:0];
                mem_wdata  = req.handle_in;
                count_next = count + ONE;
                r_hit_next = 1'b1;
              end else begin
                r_full_next = 1'b1;
              end
            end
            ohl_pkg::REQ_FIND, ohl_pkg::REQ_REMOVE_H: begin
              if (count != '0) begin
                state_next = ohl_pkg::ST_SCAN;
              end
            end
            ohl_pkg::REQ_READ, ohl_pkg::REQ_REMOVE_P: begin
              if (req.position_in != '0 && req.position_in <= count) begin
                state_next = ohl_pkg::ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ohl_pkg::ST_READ: begin
        r_hit_next    = 1'b1;
        r_handle_next = mem_rdata;
        state_next    = ohl_pkg::ST_DONE;
        if (kind == ohl_pkg::REQ_REMOVE_P) begin
          if (pos == count) begin
            count_next = count - ONE;
          end else begin
            idx_next     = pos;
            rd_pend_next = 1'b0;
            state_next   = ohl_pkg::ST_SHIFT;
          end
        end
      end

      ohl_pkg::ST_SCAN: begin
        // issue one read per cycle, compare the entry returned from the last one
        rd_pend_next = (idx < count);
        rd_idx_next  = idx;
        idx_next     = idx + ONE;
        if (rd_pend) begin
          if (mem_rdata == hnd) begin
            r_hit_next = 1'b1;
            if (kind == ohl_pkg::REQ_FIND) begin
              r_pos_next = rd_nxt;
              state_next = ohl_pkg::ST_DONE;
            end else begin
              r_handle_next = mem_rdata;
              if (rd_nxt == count) begin
                count_next = count - ONE;
                state_next = ohl_pkg::ST_DONE;
              end else begin
                idx_next     = rd_nxt;
                rd_pend_next = 1'b0;
                state_next   = ohl_pkg::ST_SHIFT;
              end
            end
          end else if (rd_nxt == count) begin
            state_next = ohl_pkg::ST_DONE;
          end
        end
      end

      ohl_pkg::ST_SHIFT: begin
        // entry i read last cycle is written to i-1 now
        rd_pend_next = (idx < count);
        rd_idx_next  = idx;
        idx_next     = idx + ONE;
        if (rd_pend) begin
          mem_we = 1'b1;
          if (rd_nxt == count) begin
            count_next   = count - ONE;
            rd_pend_next = 1'b0;
            state_next   = ohl_pkg::ST_DONE;
          end
        end
      end

      ohl_pkg::ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ohl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = ohl_pkg::ST_IDLE;
      end
    endcase
  end

  `OHL_ASSERT_NEVER(a_count_bound, clk, rst, count > DEPTH_C)
  `OHL_ASSERT_ALWAYS(a_count_step, clk, rst, (!$past(rst) && count != $past(count)) |-> (count == $past(count) + ONE || count + ONE == $past(count)))
  `OHL_ASSERT_NEVER(a_no_write_in_scan, clk, rst, mem_we && (state == ohl_pkg::ST_SCAN || state == ohl_pkg::ST_READ))
  `OHL_ASSERT_NEVER(a_pos_needs_hit, clk, rst, rsp.valid && rsp.position_out != '0 && !rsp.hit)

endmodule

>>> rtl/ordered_handle_list.sv
// Top level: ordered list of item handles with append, find, read and remove.
//
//  channel | dir | payload                                                  | handshake
//  req     | in  | req_type, handle_in, position_in                         | valid/ready
//  rsp     | out | hit, handle_out, position_out, full_error, count_out     | valid/ready
//
// Append and invalid or unknown requests go straight from IDLE to DONE; read nth also passes READ.
// Find and remove by handle scan the store one entry per cycle.
// Removes then shift later entries down one per cycle.
// Both scan and shift run through the single read and single write port of the store.
// Reset (rst, synchronous) clears the count and the sequencer; the store is not cleared.
// A response waiting in the output register does not block work on the next request.
module ordered_handle_list #(
  parameter int DEPTH        = 64,
  parameter int HANDLE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  ohl_req_if.sink   req,
  ohl_rsp_if.source rsp
);

  ohl_core #(
    .DEPTH        (DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

endmodule

>>> test/tb.sv
// Testbench for ordered_handle_list: self-checking scoreboard with random traffic and stalls.
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH        = 64;
  localparam int HANDLE_WIDTH = 32;
  localparam int POS_WIDTH    = 7;
  localparam int POOL_SIZE    = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_PCT     = 31;
  localparam int STALL_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 200;

  typedef logic [ohl_pkg::REQ_WIDTH-1:0] kind_t;

  typedef struct {
    kind_t                   kind;
    logic [HANDLE_WIDTH-1:0] handle;
    logic [POS_WIDTH-1:0]    pos;
  } list_req_t;

  typedef struct {
    logic                    hit;
    logic [HANDLE_WIDTH-1:0] handle;
    logic [POS_WIDTH-1:0]    pos;
    logic                    full;
    logic [POS_WIDTH-1:0]    count;
  } list_rsp_t;

  typedef enum {MIX_BALANCED, MIX_GROW, MIX_SHRINK} mix_t;

  // Shadow copy of the list plus the queue of responses it predicts.
  class handle_list_shadow;
    logic [HANDLE_WIDTH-1:0] entries [DEPTH];
    int unsigned held;
    int unsigned peak;
    list_rsp_t   pending_responses[$];
    int unsigned errors;
    int unsigned requests;
    int unsigned responses;
    int unsigned hits;
    int unsigned dropped;

    function new();
      held = 0;
      peak = 0;
      errors = 0;
      requests = 0;
      responses = 0;
      hits = 0;
      dropped = 0;
    endfunction

    function int unsigned locate(logic [HANDLE_WIDTH-1:0] h);
      for (int unsigned i = 0; i < held; i++) begin
        if (entries[i] == h) return i + 1;
      end
      return 0;
    endfunction

    // Pull out the entry at a 1-based slot and close the gap.
    function logic [HANDLE_WIDTH-1:0] extract_at(int unsigned slot);
      logic [HANDLE_WIDTH-1:0] v;
      v = entries[slot-1];
      for (int unsigned i = slot; i < held; i++) entries[i-1] = entries[i];
      held--;
      return v;
    endfunction

    function void note_request(list_req_t r);
      list_rsp_t   e;
      int unsigned slot;
      e = '{default: '0};
      case (r.kind)
        ohl_pkg::REQ_APPEND: begin
          if (held < DEPTH) begin
            entries[held] = r.handle;
            held++;
            e.hit = 1'b1;
          end else begin
            e.full = 1'b1;
          end
        end
        ohl_pkg::REQ_FIND: begin
          slot = locate(r.handle);
          if (slot != 0) begin
            e.hit = 1'b1;
            e.pos = slot[POS_WIDTH-1:0];
          end
        end
        ohl_pkg::REQ_READ: begin
          if (r.pos >= 1 && r.pos <= held) begin
            e.hit = 1'b1;
            e.handle = entries[r.pos-1];
          end
        end
        ohl_pkg::REQ_REMOVE_H: begin
          slot = locate(r.handle);
          if (slot != 0) begin
            e.hit = 1'b1;
            e.handle = extract_at(slot);
          end
        end
        ohl_pkg::REQ_REMOVE_P: begin
          if (r.pos >= 1 && r.pos <= held) begin
            e.hit = 1'b1;
            e.handle = extract_at(r.pos);
          end
        end
        default: ;
      endcase
      e.count = held[POS_WIDTH-1:0];
      if (held > peak) peak = held;
      if (e.hit) hits++;
      if (e.full) dropped++;
      requests++;
      pending_responses.push_back(e);
    endfunction

    function void check_response(list_rsp_t a);
      list_rsp_t e;
      responses++;
      if (pending_responses.size() == 0) begin
        $error("unexpected response transaction: nothing outstanding");
        errors++;
        return;
      end
      e = pending_responses.pop_front();
      if (a.hit !== e.hit) begin
        $error("hit: expected %0h, actual %0h", e.hit, a.hit);
        errors++;
      end
      if (a.handle !== e.handle) begin
        $error("handle_out: expected %0h, actual %0h", e.handle, a.handle);
        errors++;
      end
      if (a.pos !== e.pos) begin
        $error("position_out: expected %0d, actual %0d", e.pos, a.pos);
        errors++;
      end
      if (a.full !== e.full) begin
        $error("full_error: expected %0h, actual %0h", e.full, a.full);
        errors++;
      end
      if (a.count !== e.count) begin
        $error("count_out: expected %0d, actual %0d", e.count, a.count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  ohl_req_if #(.HANDLE_WIDTH(HANDLE_WIDTH), .POS_WIDTH(POS_WIDTH)) req_ch();
  ohl_rsp_if #(.HANDLE_WIDTH(HANDLE_WIDTH), .POS_WIDTH(POS_WIDTH)) rsp_ch();

  ordered_handle_list #(.DEPTH(DEPTH), .HANDLE_WIDTH(HANDLE_WIDTH)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  always #4 clk = ~clk;

  handle_list_shadow       shadow = new();
  logic [HANDLE_WIDTH-1:0] pool [POOL_SIZE];
  bit                      idle_on = 1'b1;
  int unsigned             holds_asked = 0;
  int unsigned             holds_done = 0;
  int unsigned             quiet_cycles = 0;

  // Response side: random backpressure, plus a long hold-off when asked.
  initial begin
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (holds_done != holds_asked) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        rsp_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      shadow.check_response('{rsp_ch.hit, rsp_ch.handle_out, rsp_ch.position_out,
                              rsp_ch.full_error, rsp_ch.count_out});
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  function automatic list_req_t mk(kind_t kind, logic [HANDLE_WIDTH-1:0] h,
                                   logic [POS_WIDTH-1:0] p);
    list_req_t r;
    r.kind = kind;
    r.handle = h;
    r.pos = p;
    return r;
  endfunction

  function automatic logic [HANDLE_WIDTH-1:0] any_handle();
    if ($urandom_range(99) < 70) return pool[$urandom_range(POOL_SIZE-1)];
    return $urandom;
  endfunction

  function automatic list_req_t pick(mix_t mix);
    list_req_t   r;
    int unsigned roll;
    int unsigned n;
    int unsigned cut [5];
    n = shadow.held;
    case (mix)
      MIX_GROW:   cut = '{60, 70, 80, 85, 92};
      MIX_SHRINK: cut = '{10, 20, 35, 65, 97};
      default:    cut = '{30, 45, 60, 75, 95};
    endcase
    roll = $urandom_range(99);
    if (roll < cut[0]) r.kind = ohl_pkg::REQ_APPEND;
    else if (roll < cut[1]) r.kind = ohl_pkg::REQ_FIND;
    else if (roll < cut[2]) r.kind = ohl_pkg::REQ_READ;
    else if (roll < cut[3]) r.kind = ohl_pkg::REQ_REMOVE_H;
    else if (roll < cut[4]) r.kind = ohl_pkg::REQ_REMOVE_P;
    else r.kind = kind_t'($urandom_range(7, ohl_pkg::REQ_REMOVE_P + 1));
    // Lookups mostly target handles that are really held.
    if (n > 0 && $urandom_range(99) < 60 &&
        (r.kind == ohl_pkg::REQ_FIND || r.kind == ohl_pkg::REQ_REMOVE_H))
      r.handle = shadow.entries[$urandom_range(n-1)];
    else
      r.handle = any_handle();
    roll = $urandom_range(99);
    if (n > 0 && roll < 80) r.pos = POS_WIDTH'($urandom_range(n, 1));
    else if (roll < 90) r.pos = POS_WIDTH'($urandom_range(1) ? n + 1 : 0);
    else r.pos = POS_WIDTH'($urandom_range(127));
    return r;
  endfunction

  task automatic offer(input list_req_t r);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= r.kind;
    req_ch.handle_in <= r.handle;
    req_ch.position_in <= r.pos;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    shadow.note_request(r);
  endtask

  task automatic run_mix(input mix_t mix, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) offer(pick(mix));
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (shadow.pending_responses.size() != 0) @(posedge clk);
  endtask

  initial begin
    req_ch.valid <= 1'b0;
    req_ch.req_type <= ohl_pkg::REQ_APPEND;
    req_ch.handle_in <= '0;
    req_ch.position_in <= '0;
    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) pool[i] = $urandom;

    // Directed: empty list, extremes, duplicates, bad positions, unknown kinds.
    offer(mk(ohl_pkg::REQ_READ, '0, 7'd1));
    offer(mk(ohl_pkg::REQ_REMOVE_P, '0, 7'd0));
    offer(mk(ohl_pkg::REQ_FIND, '0, 7'd0));
    offer(mk(ohl_pkg::REQ_REMOVE_H, '0, 7'd0));
    offer(mk(ohl_pkg::REQ_APPEND, '0, 7'd127));
    offer(mk(ohl_pkg::REQ_APPEND, '1, 7'd0));
    offer(mk(ohl_pkg::REQ_APPEND, 32'h1234_5678, 7'd0));
    offer(mk(ohl_pkg::REQ_APPEND, 32'h1234_5678, 7'd64));
    offer(mk(ohl_pkg::REQ_APPEND, 32'hA5A5_5A5A, 7'd0));
    offer(mk(ohl_pkg::REQ_FIND, 32'h1234_5678, 7'd0));
    offer(mk(ohl_pkg::REQ_FIND, 32'hDEAD_BEEF, 7'd0));
    offer(mk(ohl_pkg::REQ_READ, '1, 7'd0));
    offer(mk(ohl_pkg::REQ_READ, '0, 7'd1));
    offer(mk(ohl_pkg::REQ_READ, '0, 7'd5));
    offer(mk(ohl_pkg::REQ_READ, '0, 7'd6));
    offer(mk(ohl_pkg::REQ_READ, '0, 7'd127));
    offer(mk(ohl_pkg::REQ_REMOVE_H, 32'h1234_5678, 7'd0));
    offer(mk(ohl_pkg::REQ_FIND, 32'h1234_5678, 7'd0));
    offer(mk(ohl_pkg::REQ_REMOVE_H, 32'hDEAD_BEEF, 7'd0));
    offer(mk(ohl_pkg::REQ_REMOVE_P, '0, 7'd1));
    offer(mk(ohl_pkg::REQ_REMOVE_P, '0, 7'd64));
    for (int j = 1; j <= 3; j++)
      offer(mk(kind_t'(ohl_pkg::REQ_REMOVE_P + j), $urandom,
               POS_WIDTH'($urandom_range(127))));
    offer(mk(ohl_pkg::REQ_REMOVE_P, '1, 7'd3));

    run_mix(MIX_BALANCED, 120);

    // Fill to the top, then push appends that must be dropped.
    while (shadow.held < DEPTH) begin
      if ($urandom_range(7) == 0) offer(pick(MIX_BALANCED));
      else offer(mk(ohl_pkg::REQ_APPEND, any_handle(), POS_WIDTH'($urandom_range(127))));
    end
    repeat (4) offer(mk(ohl_pkg::REQ_APPEND, any_handle(), 7'd0));
    offer(mk(ohl_pkg::REQ_READ, '0, 7'd64));
    offer(mk(ohl_pkg::REQ_FIND, shadow.entries[DEPTH-1], 7'd0));
    offer(mk(ohl_pkg::REQ_REMOVE_P, '0, 7'd1));
    offer(mk(ohl_pkg::REQ_APPEND, '1, 7'd0));
    offer(mk(ohl_pkg::REQ_REMOVE_P, '0, 7'd64));
    run_mix(MIX_BALANCED, 15);

    // Receiver holds off while requests keep coming, so the block backs up.
    holds_asked++;
    run_mix(MIX_BALANCED, 20);
    wait_drained();

    idle_on = 1'b0;
    run_mix(MIX_GROW, 50);
    run_mix(MIX_BALANCED, 50);
    idle_on = 1'b1;

    run_mix(MIX_SHRINK, 100);
    run_mix(MIX_BALANCED, 40);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d requests and checked %0d responses: %0d hits, %0d full drops",
             shadow.requests, shadow.responses, shadow.hits, shadow.dropped);
    $display("list depth peaked at %0d of %0d; %0d mismatches", shadow.peak, DEPTH,
             shadow.errors);
    if (shadow.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
